// File: design/tmvr_pkg.sv
// shared types, constants and codes of the tile map view renderer
`timescale 1ns / 1ps

package tmvr_pkg;

   // default sizes of the map store and render limit
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_TILE_BITS = 10;
   localparam int DEF_MAX_EMIT  = 64;

   // fixed field widths
   localparam int CAM_W      = 16;
   localparam int COORD_W    = 14;
   localparam int SRC_TOP_W  = 18;
   localparam int SRC_RGT_W  = 15;
   localparam int SRC_BOT_W  = 19;
   localparam int SIZE_W     = 9;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // shared divider and multiplier widths
   localparam int DIV_W   = 16;
   localparam int DVS_W   = 9;
   localparam int MUL_A_W = 9;
   localparam int MUL_B_W = 16;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;

   // register reset values and saturation limits
   localparam logic [SIZE_W-1:0]  TILE_SIZE_RST  = 9'd16;
   localparam logic [COUNT_W-1:0] MAP_COUNT_RST  = 7'd64;
   localparam logic [COUNT_W-1:0] SHEET_COLS_RST = 7'd8;
   localparam logic [SIZE_W-1:0]  TILE_SIZE_MAX  = 9'd256;
   localparam logic [SIZE_W-1:0]  SHEET_COLS_MAX = 9'd64;

   // transaction kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   // camera edge slots
   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_TOP    = 2'd1;
   localparam logic [1:0] EDGE_RIGHT  = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TILE_WIDTH  = 3'd0,
      REG_TILE_HEIGHT = 3'd1,
      REG_MAP_ROWS    = 3'd2,
      REG_MAP_COLS    = 3'd3,
      REG_SHEET_COLS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                    req_type;
      logic [5:0]              load_row;
      logic [5:0]              load_col;
      logic [9:0]              tile_value;
      logic signed [CAM_W-1:0] cam_left;
      logic signed [CAM_W-1:0] cam_top;
      logic signed [CAM_W-1:0] cam_right;
      logic signed [CAM_W-1:0] cam_bottom;
   } tmvr_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]   x_world;
      logic [COORD_W-1:0]   y_world;
      logic [COORD_W-1:0]   src_left;
      logic [SRC_TOP_W-1:0] src_top;
      logic [SRC_RGT_W-1:0] src_right;
      logic [SRC_BOT_W-1:0] src_bottom;
      logic                 last;
      logic                 truncated;
   } tmvr_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_GO,
      ST_EDGE_WAIT,
      ST_CLIP,
      ST_CHECK,
      ST_SETUP,
      ST_XSET,
      ST_YSET,
      ST_READ,
      ST_TILE_GO,
      ST_TILE_WAIT,
      ST_MUL_L,
      ST_MUL_T,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_TOTAL,
      MUL_XBASE,
      MUL_YBASE,
      MUL_SL,
      MUL_ST
   } mul_op_type;

   typedef struct packed {
      logic       load_wr;
      logic       cap;
      logic       edge_go;
      logic       edge_save;
      logic [1:0] edge_idx;
      logic       clip;
      mul_op_type mul_op;
      logic       setup;
      logic       x_init;
      logic       y_init;
      logic       rd;
      logic       tile_go;
      logic       sl_save;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic empty;
      logic last;
   } dp_status_type;

endpackage

// File: design/tmvr_ram.sv
// generic single-write, registered-read ram
`timescale 1ns / 1ps

module tmvr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/tmvr_div.sv
// iterative restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps

module tmvr_div
   import tmvr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W:0]     shifted;
   logic               fits;

   always_comb begin
      shifted   = {rem_ff, quo_ff[DIV_W-1]};
      fits      = shifted >= {1'b0, dvs_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(DIV_W);
         quo_in    = dividend;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         rem_in = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : DVS_W'(shifted);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: design/tmvr_datapath.sv
// registers, map store, shared divider and multiplier of the renderer
`timescale 1ns / 1ps

module tmvr_datapath
   import tmvr_pkg::*;
#(
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int TILE_BITS = DEF_TILE_BITS,
   parameter int MAX_EMIT  = DEF_MAX_EMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tmvr_req_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output tmvr_rsp_type          rsp_data
);

   localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NR_W  = $clog2(MAX_ROWS + 1);
   localparam int NC_W  = $clog2(MAX_COLS + 1);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW    = $clog2(MAX_EMIT + 1);

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // configuration registers
   logic [SIZE_W-1:0]  tw_reg_ff, th_reg_ff;
   logic [COUNT_W-1:0] rows_reg_ff, cols_reg_ff, sc_reg_ff;
   logic [SIZE_W-1:0]  tw_c, th_c, sc_w, rows_w, cols_w;
   logic [NR_W-1:0]    rows_c;
   logic [NC_W-1:0]    cols_c;

   // camera and edge quotients
   logic signed [CAM_W-1:0] cam_ff [4];
   logic [DIV_W-1:0]        q_ff [4];
   logic [3:0]              neg_ff;
   logic signed [CAM_W-1:0] edge_val;
   logic [DIV_W-1:0]        edge_mag;

   // clipped tile window
   logic [DIV_W-1:0] l_lo, t_lo, r_hi, b_hi;
   logic             empty_in;
   logic [CI_W-1:0]  l_ff, r_ff, col_ff;
   logic [RI_W-1:0]  t_ff, b_ff, row_ff;
   logic             empty_ff;
   logic [NC_W-1:0]  ncols;
   logic [NR_W-1:0]  nrows;

   // shared divider
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quo;
   logic [DVS_W-1:0] div_divisor, div_rem;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_W-1:0]   mul_ff;

   // walk state
   logic [EW-1:0]      k_ff, emit_n_ff;
   logic               trunc_ff, last_w, over_w;
   logic [COORD_W-1:0] x_ff, xbase_ff, y_ff;
   logic [COORD_W-1:0] sl_ff;

   // map store
   logic                 wr_ok, ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [TILE_BITS-1:0] ram_rdata;

   tmvr_rsp_type rsp_ff;
   logic         rsp_valid_ff;

   assign tw_c   = clamp_size(tw_reg_ff, TILE_SIZE_MAX);
   assign th_c   = clamp_size(th_reg_ff, TILE_SIZE_MAX);
   assign sc_w   = clamp_size({2'b00, sc_reg_ff}, SHEET_COLS_MAX);
   assign rows_w = clamp_size({2'b00, rows_reg_ff}, SIZE_W'(MAX_ROWS));
   assign cols_w = clamp_size({2'b00, cols_reg_ff}, SIZE_W'(MAX_COLS));
   assign rows_c = NR_W'(rows_w);
   assign cols_c = NC_W'(cols_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_reg_ff   <= TILE_SIZE_RST;
         th_reg_ff   <= TILE_SIZE_RST;
         rows_reg_ff <= MAP_COUNT_RST;
         cols_reg_ff <= MAP_COUNT_RST;
         sc_reg_ff   <= SHEET_COLS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TILE_WIDTH:  tw_reg_ff   <= csr_data;
            REG_TILE_HEIGHT: th_reg_ff   <= csr_data;
            REG_MAP_ROWS:    rows_reg_ff <= csr_data[COUNT_W-1:0];
            REG_MAP_COLS:    cols_reg_ff <= csr_data[COUNT_W-1:0];
            REG_SHEET_COLS:  sc_reg_ff   <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // map store write on load transactions inside the map bounds
   assign wr_ok     = (req_data.load_row < MAX_ROWS) && (req_data.load_col < MAX_COLS);
   assign ram_we    = cmd.load_wr && wr_ok;
   assign ram_waddr = AW'(req_data.load_row * MAX_COLS + req_data.load_col);
   assign ram_raddr = AW'(row_ff * MAX_COLS + col_ff);

   tmvr_ram #(
      .WIDTH (TILE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (TILE_BITS'(req_data.tile_value)),
      .re    (cmd.rd),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // edge magnitude for truncating division toward zero
   assign edge_val = cam_ff[cmd.edge_idx];
   assign edge_mag = edge_val[CAM_W-1] ? DIV_W'(-edge_val) : DIV_W'(edge_val);

   assign div_start    = cmd.edge_go || cmd.tile_go;
   assign div_dividend = cmd.tile_go ? DIV_W'(ram_rdata) : edge_mag;
   assign div_divisor  = cmd.tile_go ? DVS_W'(sc_w)
                                     : (cmd.edge_idx[0] ? DVS_W'(th_c) : DVS_W'(tw_c));

   tmvr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         cam_ff[EDGE_LEFT]   <= req_data.cam_left;
         cam_ff[EDGE_TOP]    <= req_data.cam_top;
         cam_ff[EDGE_RIGHT]  <= req_data.cam_right;
         cam_ff[EDGE_BOTTOM] <= req_data.cam_bottom;
      end
      if (cmd.edge_save) begin
         q_ff[cmd.edge_idx]   <= div_quo;
         neg_ff[cmd.edge_idx] <= edge_val[CAM_W-1] && (div_quo != '0);
      end
   end

   // clip the tile window to the map
   always_comb begin
      l_lo = neg_ff[EDGE_LEFT] ? '0 : q_ff[EDGE_LEFT];
      t_lo = neg_ff[EDGE_TOP]  ? '0 : q_ff[EDGE_TOP];
      r_hi = (q_ff[EDGE_RIGHT] >= DIV_W'(cols_c)) ? DIV_W'(cols_c - NC_W'(1))
                                                  : q_ff[EDGE_RIGHT];
      b_hi = (q_ff[EDGE_BOTTOM] >= DIV_W'(rows_c)) ? DIV_W'(rows_c - NR_W'(1))
                                                   : q_ff[EDGE_BOTTOM];
      empty_in = neg_ff[EDGE_RIGHT] || neg_ff[EDGE_BOTTOM] || (r_hi < l_lo) || (b_hi < t_lo);
   end

   assign ncols = NC_W'(r_ff) - NC_W'(l_ff) + NC_W'(1);
   assign nrows = NR_W'(b_ff) - NR_W'(t_ff) + NR_W'(1);

   always_comb begin
      case (cmd.mul_op)
         MUL_TOTAL: begin
            mul_a = MUL_A_W'(ncols);
            mul_b = MUL_B_W'(nrows);
         end
         MUL_XBASE: begin
            mul_a = MUL_A_W'(tw_c);
            mul_b = MUL_B_W'(l_ff);
         end
         MUL_YBASE: begin
            mul_a = MUL_A_W'(th_c);
            mul_b = MUL_B_W'(t_ff);
         end
         MUL_SL: begin
            mul_a = MUL_A_W'(tw_c);
            mul_b = MUL_B_W'(div_rem);
         end
         MUL_ST: begin
            mul_a = MUL_A_W'(th_c);
            mul_b = MUL_B_W'(div_quo);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign over_w = mul_ff > MUL_W'(MAX_EMIT);
   assign last_w = (k_ff + EW'(1)) == emit_n_ff;

   always_ff @(posedge clock) begin
      if (cmd.clip) begin
         l_ff     <= CI_W'(l_lo);
         r_ff     <= CI_W'(r_hi);
         t_ff     <= RI_W'(t_lo);
         b_ff     <= RI_W'(b_hi);
         empty_ff <= empty_in;
      end
      if (cmd.mul_op != MUL_NONE) begin
         mul_ff <= MUL_W'(mul_a) * MUL_W'(mul_b);
      end
      if (cmd.setup) begin
         trunc_ff  <= over_w;
         emit_n_ff <= over_w ? EW'(MAX_EMIT) : EW'(mul_ff);
         k_ff      <= '0;
         row_ff    <= t_ff;
         col_ff    <= l_ff;
      end
      if (cmd.x_init) begin
         x_ff     <= mul_ff[COORD_W-1:0];
         xbase_ff <= mul_ff[COORD_W-1:0];
      end
      if (cmd.y_init) begin
         y_ff <= mul_ff[COORD_W-1:0];
      end
      if (cmd.sl_save) begin
         sl_ff <= mul_ff[COORD_W-1:0];
      end
      if (cmd.emit) begin
         rsp_ff.x_world    <= x_ff;
         rsp_ff.y_world    <= y_ff;
         rsp_ff.src_left   <= sl_ff;
         rsp_ff.src_top    <= mul_ff[SRC_TOP_W-1:0];
         rsp_ff.src_right  <= SRC_RGT_W'(sl_ff) + SRC_RGT_W'(tw_c);
         rsp_ff.src_bottom <= mul_ff[SRC_BOT_W-1:0] + SRC_BOT_W'(th_c);
         rsp_ff.last       <= last_w;
         rsp_ff.truncated  <= last_w && trunc_ff;
         k_ff              <= k_ff + EW'(1);
         // step left to right, then wrap to the next row
         if (col_ff == r_ff) begin
            col_ff <= l_ff;
            row_ff <= row_ff + RI_W'(1);
            x_ff   <= xbase_ff;
            y_ff   <= y_ff + COORD_W'(th_c);
         end else begin
            col_ff <= col_ff + CI_W'(1);
            x_ff   <= x_ff + COORD_W'(tw_c);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign status.div_done = div_done;
   assign status.empty    = empty_ff;
   assign status.last     = last_w;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// File: design/tmvr_ctrl.sv
// sequencing state machine of the renderer
`timescale 1ns / 1ps

module tmvr_ctrl
   import tmvr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_kind,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     edge_ff, edge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         edge_ff  <= EDGE_LEFT;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      edge_in      = edge_ff;
      cmd          = '0;
      cmd.mul_op   = MUL_NONE;
      cmd.edge_idx = edge_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == REQ_RENDER) begin
                  cmd.cap  = 1'b1;
                  edge_in  = EDGE_LEFT;
                  state_in = ST_EDGE_GO;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_EDGE_GO: begin
            cmd.edge_go = 1'b1;
            state_in    = ST_EDGE_WAIT;
         end
         ST_EDGE_WAIT: begin
            if (status.div_done) begin
               cmd.edge_save = 1'b1;
               if (edge_ff == EDGE_BOTTOM) begin
                  state_in = ST_CLIP;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  state_in = ST_EDGE_GO;
               end
            end
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mul_op = MUL_TOTAL;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup  = 1'b1;
            cmd.mul_op = MUL_XBASE;
            state_in   = ST_XSET;
         end
         ST_XSET: begin
            cmd.x_init = 1'b1;
            cmd.mul_op = MUL_YBASE;
            state_in   = ST_YSET;
         end
         ST_YSET: begin
            cmd.y_init = 1'b1;
            state_in   = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_TILE_GO;
         end
         ST_TILE_GO: begin
            cmd.tile_go = 1'b1;
            state_in    = ST_TILE_WAIT;
         end
         ST_TILE_WAIT: begin
            if (status.div_done) begin
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L: begin
            cmd.mul_op = MUL_SL;
            state_in   = ST_MUL_T;
         end
         ST_MUL_T: begin
            cmd.sl_save = 1'b1;
            cmd.mul_op  = MUL_ST;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: design/tile_map_view_renderer.sv
// top level of the tile map view renderer
`timescale 1ns / 1ps

// Tile map view renderer. A transaction is taken when start is high and busy is low.
// A load transaction writes one tile index into the map store in that same cycle and
// gives no result; busy stays low. A render transaction divides the four camera edges
// by the tile size (truncating toward zero), clips the tile window to the map and then
// walks it row by row, left to right, giving one result per tile for up to MAX_EMIT
// tiles. Every result is marked on rsp_data by rsp_valid, high for exactly one cycle;
// the receiver cannot stall the block and must take each result as it appears. The
// final result of a render carries last, and truncated too when tiles were dropped.
// A view that covers no tile gives no result at all. The map store has no reset; an
// entry should be loaded before any render reads it. Configuration writes must be
// made only while busy is low; the block itself does not enforce this.
// The busy time of a render is set by the shared 16-step iterative divider: four
// divisions for the camera edges, and one more per tile for the tilesheet row and
// column, and each result waits for its own division.

module tile_map_view_renderer
   import tmvr_pkg::*;
#(
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int TILE_BITS = DEF_TILE_BITS,
   parameter int MAX_EMIT  = DEF_MAX_EMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  start,
   output logic                  busy,
   input  tmvr_req_type          req_data,
   // result side, one cycle strobe, no back-pressure
   output logic                  rsp_valid,
   output tmvr_rsp_type          rsp_data,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: decides which datapath step runs each cycle
   tmvr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath: registers, map store, divider, multiplier and result register
   tmvr_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .TILE_BITS (TILE_BITS),
      .MAX_EMIT  (MAX_EMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the tile map view renderer
`timescale 1ns / 1ps

module tb_top;
   import tmvr_pkg::*;

   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int PHASES        = 8;
   localparam int ITEMS_PER_PH  = 45;
   localparam int SCRIPT_MAX    = 32;
   localparam int REQ_W         = $bits(tmvr_req_type);

   // ports of the block; the inputs are known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   tmvr_req_type          req_data  = '0;
   logic                  rsp_valid;
   tmvr_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // shadow copy of the registers as last written
   logic [SIZE_W-1:0]  cfg_tw   = TILE_SIZE_RST;
   logic [SIZE_W-1:0]  cfg_th   = TILE_SIZE_RST;
   logic [COUNT_W-1:0] cfg_rows = MAP_COUNT_RST;
   logic [COUNT_W-1:0] cfg_cols = MAP_COUNT_RST;
   logic [COUNT_W-1:0] cfg_sc   = SHEET_COLS_RST;

   // shadow copy of the map store and which entries hold a loaded value
   logic [DEF_TILE_BITS-1:0] map_copy    [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
   bit                       map_written [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];

   // tiles still owed by the block, oldest first
   tmvr_rsp_type tiles_due [$];

   // clipped tile window of the view under test
   int win_l, win_t, win_r, win_b;

   int          mismatches  = 0;
   int          idle_pct    = 0;
   int unsigned cycle_count = 0;

   // directed stimulus table: n_typed of -1 means the predictor decides
   tmvr_req_type script_rq   [0:SCRIPT_MAX-1];
   int           script_n    [0:SCRIPT_MAX-1];
   tmvr_rsp_type script_tile [0:SCRIPT_MAX-1];
   int           script_len = 0;

   tile_map_view_renderer DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs or drops a tile
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // register saturation: zero counts as one, anything above the top counts as the top
   function automatic int sat(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // every field random, so unused fields toggle too
   function automatic tmvr_req_type noise_item();
      logic [95:0] noise;
      tmvr_req_type rq;
      noise = {$urandom, $urandom, $urandom};
      rq = noise[REQ_W-1:0];
      return rq;
   endfunction

   function automatic tmvr_req_type load_item(input int row, input int col, input int val);
      tmvr_req_type rq;
      rq = noise_item();
      rq.req_type   = REQ_LOAD;
      rq.load_row   = 6'(row);
      rq.load_col   = 6'(col);
      rq.tile_value = 10'(val);
      return rq;
   endfunction

   function automatic tmvr_req_type view_item(input int l, input int t, input int r, input int b);
      tmvr_req_type rq;
      rq = noise_item();
      rq.req_type   = REQ_RENDER;
      rq.cam_left   = CAM_W'(l);
      rq.cam_top    = CAM_W'(t);
      rq.cam_right  = CAM_W'(r);
      rq.cam_bottom = CAM_W'(b);
      return rq;
   endfunction

   function automatic tmvr_rsp_type tile_rsp(input int x, input int y, input int sl,
                                             input int st, input int sr, input int sb,
                                             input bit fin, input bit trunc);
      tmvr_rsp_type tile;
      tile.x_world    = COORD_W'(x);
      tile.y_world    = COORD_W'(y);
      tile.src_left   = COORD_W'(sl);
      tile.src_top    = SRC_TOP_W'(st);
      tile.src_right  = SRC_RGT_W'(sr);
      tile.src_bottom = SRC_BOT_W'(sb);
      tile.last       = fin;
      tile.truncated  = trunc;
      return tile;
   endfunction

   function automatic void add_row(input tmvr_req_type rq, input int n_typed,
                                   input tmvr_rsp_type tile);
      script_rq[script_len]   = rq;
      script_n[script_len]    = n_typed;
      script_tile[script_len] = tile;
      script_len++;
   endfunction

   // edges divided by the tile size (truncating toward zero), then clipped to the map;
   // returns the number of visible tiles, zero when the window is empty
   function automatic int view_window(input tmvr_req_type rq);
      int tw, th, rows, cols, edge_px;
      tw   = sat(int'(cfg_tw), int'(TILE_SIZE_MAX));
      th   = sat(int'(cfg_th), int'(TILE_SIZE_MAX));
      rows = sat(int'(cfg_rows), DEF_MAX_ROWS);
      cols = sat(int'(cfg_cols), DEF_MAX_COLS);
      edge_px = $signed(rq.cam_left);
      win_l = edge_px / tw;
      edge_px = $signed(rq.cam_top);
      win_t = edge_px / th;
      edge_px = $signed(rq.cam_right);
      win_r = edge_px / tw;
      edge_px = $signed(rq.cam_bottom);
      win_b = edge_px / th;
      if (win_l < 0) win_l = 0;
      if (win_t < 0) win_t = 0;
      if (win_r >= cols) win_r = cols - 1;
      if (win_b >= rows) win_b = rows - 1;
      if (win_r < win_l || win_b < win_t) return 0;
      return (win_r - win_l + 1) * (win_b - win_t + 1);
   endfunction

   // works out the tiles a render transaction gives, in row order
   function automatic void predict_view(input tmvr_req_type rq);
      int total, n, k, row, col, tw, th, sc, v, sl, st;
      tmvr_rsp_type tile;
      total = view_window(rq);
      n  = (total > DEF_MAX_EMIT) ? DEF_MAX_EMIT : total;
      tw = sat(int'(cfg_tw), int'(TILE_SIZE_MAX));
      th = sat(int'(cfg_th), int'(TILE_SIZE_MAX));
      sc = sat(int'(cfg_sc), int'(SHEET_COLS_MAX));
      row = win_t;
      col = win_l;
      for (k = 0; k < n; k++) begin
         v  = int'(map_copy[row * DEF_MAX_COLS + col]);
         sl = tw * (v % sc);
         st = th * (v / sc);
         tiles_due.push_back(tile_rsp(col * tw, row * th, sl, st, sl + tw, st + th,
                                      k == n - 1, (k == n - 1) && (total > DEF_MAX_EMIT)));
         if (col == win_r) begin
            col = win_l;
            row++;
         end else begin
            col++;
         end
      end
   endfunction

   // shadow update once a transaction is taken
   function automatic void absorb_item(input tmvr_req_type rq, input int n_typed,
                                       input tmvr_rsp_type tile);
      int addr;
      addr = int'(rq.load_row) * DEF_MAX_COLS + int'(rq.load_col);
      if (rq.req_type == REQ_LOAD) begin
         map_copy[addr]    = rq.tile_value;
         map_written[addr] = 1'b1;
      end else if (n_typed < 0) begin
         predict_view(rq);
      end else if (n_typed == 1) begin
         tiles_due.push_back(tile);
      end
   endfunction

   // random view over the current map: mostly sane windows, some broken or wild ones
   function automatic tmvr_req_type random_view();
      tmvr_req_type rq;
      int tw, th, rows, cols, lc, tc, wc, hc, l, t, r, b, swap, pick;
      tw   = sat(int'(cfg_tw), int'(TILE_SIZE_MAX));
      th   = sat(int'(cfg_th), int'(TILE_SIZE_MAX));
      rows = sat(int'(cfg_rows), DEF_MAX_ROWS);
      cols = sat(int'(cfg_cols), DEF_MAX_COLS);
      lc = $urandom_range(cols - 1, 0);
      tc = $urandom_range(rows - 1, 0);
      wc = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
      hc = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
      l = lc * tw + int'($urandom_range(tw - 1, 0));
      t = tc * th + int'($urandom_range(th - 1, 0));
      r = (lc + wc - 1) * tw + int'($urandom_range(tw - 1, 0));
      b = (tc + hc - 1) * th + int'($urandom_range(th - 1, 0));
      // small negative edges round toward zero, so still land on the first tile
      if (lc == 0 && $urandom_range(3) == 0) l = -int'($urandom_range(tw - 1, 0));
      if (tc == 0 && $urandom_range(3) == 0) t = -int'($urandom_range(th - 1, 0));
      pick = $urandom_range(99);
      if (pick < 5) begin
         swap = l; l = r; r = swap;
      end else if (pick < 10) begin
         swap = t; t = b; b = swap;
      end else if (pick < 16) begin
         l += cols * tw; r += cols * tw;
      end else if (pick < 22) begin
         t += rows * th; b += rows * th;
      end else if (pick < 30) begin
         l = $urandom; t = $urandom; r = $urandom; b = $urandom;
      end
      rq = view_item(l, t, r, b);
      return rq;
   endfunction

   // one transaction: optional idle gap, then start held until busy is seen low at an edge
   task automatic send_item(input tmvr_req_type rq, input int n_typed,
                            input tmvr_rsp_type tile);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      absorb_item(rq, n_typed, tile);
   endtask

   // loads every map entry a render would read that has never been written
   task automatic preload_view(input tmvr_req_type rq);
      int total, n, k, row, col, l, r;
      total = view_window(rq);
      n   = (total > DEF_MAX_EMIT) ? DEF_MAX_EMIT : total;
      l   = win_l;
      r   = win_r;
      row = win_t;
      col = win_l;
      for (k = 0; k < n; k++) begin
         if (!map_written[row * DEF_MAX_COLS + col])
            send_item(load_item(row, col, $urandom), -1, '0);
         if (col == r) begin
            col = l;
            row++;
         end else begin
            col++;
         end
      end
   endtask

   // hold off until every owed tile is in and the block is idle
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (tiles_due.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         REG_TILE_WIDTH:  cfg_tw   = val;
         REG_TILE_HEIGHT: cfg_th   = val;
         REG_MAP_ROWS:    cfg_rows = val[COUNT_W-1:0];
         REG_MAP_COLS:    cfg_cols = val[COUNT_W-1:0];
         REG_SHEET_COLS:  cfg_sc   = val[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // all five registers, then junk to the unused indexes, which must not alias
   task automatic apply_setting(input int tw, input int th, input int rows,
                                input int cols, input int sc);
      int k;
      write_reg(REG_TILE_WIDTH, CSR_DATA_W'(tw));
      write_reg(REG_TILE_HEIGHT, CSR_DATA_W'(th));
      write_reg(REG_MAP_ROWS, CSR_DATA_W'(rows));
      write_reg(REG_MAP_COLS, CSR_DATA_W'(cols));
      write_reg(REG_SHEET_COLS, CSR_DATA_W'(sc));
      for (k = int'(REG_SHEET_COLS) + 1; k < (1 << CSR_IDX_W); k++)
         write_reg(CSR_IDX_W'(k), CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // result checker: the block cannot be stalled, so every strobe is a transaction
   task automatic check_tile(input tmvr_rsp_type got);
      tmvr_rsp_type want;
      if (tiles_due.size() == 0) begin
         $error("tile result with nothing owed: x_world %0d, y_world %0d",
                got.x_world, got.y_world);
         mismatches++;
         return;
      end
      want = tiles_due.pop_front();
      if (got.x_world !== want.x_world) begin
         $error("x_world: expected %0d, got %0d", want.x_world, got.x_world);
         mismatches++;
      end
      if (got.y_world !== want.y_world) begin
         $error("y_world: expected %0d, got %0d", want.y_world, got.y_world);
         mismatches++;
      end
      if (got.src_left !== want.src_left) begin
         $error("src_left: expected %0d, got %0d", want.src_left, got.src_left);
         mismatches++;
      end
      if (got.src_top !== want.src_top) begin
         $error("src_top: expected %0d, got %0d", want.src_top, got.src_top);
         mismatches++;
      end
      if (got.src_right !== want.src_right) begin
         $error("src_right: expected %0d, got %0d", want.src_right, got.src_right);
         mismatches++;
      end
      if (got.src_bottom !== want.src_bottom) begin
         $error("src_bottom: expected %0d, got %0d", want.src_bottom, got.src_bottom);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         mismatches++;
      end
      if (got.truncated !== want.truncated) begin
         $error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) check_tile(rsp_data);
   end

   initial begin
      tmvr_req_type rq;
      int i, ph;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset register values: 16 px tiles, 64 x 64 map, 8 sheet columns
      add_row(load_item(0, 0, 0), 0, '0);
      add_row(view_item(0, 0, 15, 15), 1, tile_rsp(0, 0, 0, 0, 16, 16, 1, 0));
      // top corner of the map holding the top tile index
      add_row(load_item(63, 63, 1023), 0, '0);
      add_row(view_item(1008, 1008, 32767, 32767), 1,
              tile_rsp(1008, 1008, 112, 2032, 128, 2048, 1, 0));
      // minus one rounds toward zero, so the view still covers the first tile
      add_row(view_item(-32768, -32768, -1, -1), 1, tile_rsp(0, 0, 0, 0, 16, 16, 1, 0));
      // views covering nothing: wholly negative, right before left, bottom above top,
      // past the map edge, and every edge at its opposite extreme
      add_row(view_item(-32768, -32768, -17, -17), 0, '0);
      add_row(view_item(100, 0, 50, 0), 0, '0);
      add_row(view_item(0, 100, 0, 50), 0, '0);
      add_row(view_item(1024, 0, 2000, 15), 0, '0);
      add_row(view_item(0, 1024, 15, 32767), 0, '0);
      add_row(view_item(32767, 32767, -32768, -32768), 0, '0);
      // overwrite of a loaded entry
      add_row(load_item(0, 0, 9), 0, '0);
      add_row(view_item(0, 0, 0, 0), 1, tile_rsp(0, 0, 16, 16, 32, 32, 1, 0));
      // alternating bit patterns in the tile index and position fields
      add_row(load_item(42, 21, 10'h2AA), 0, '0);
      add_row(load_item(21, 42, 10'h155), 0, '0);
      add_row(view_item(336, 672, 351, 687), -1, '0);
      add_row(view_item(672, 336, 687, 351), -1, '0);
      add_row(view_item(-5, -5, 40, 40), -1, '0);
      // exactly the render limit, one over it, and the whole map
      add_row(view_item(0, 0, 127, 127), -1, '0);
      add_row(view_item(0, 0, 192, 64), -1, '0);
      add_row(view_item(-32768, -32768, 32767, 32767), -1, '0);

      idle_pct = 26;
      for (i = 0; i < script_len; i++) begin
         if (script_rq[i].req_type == REQ_RENDER) preload_view(script_rq[i]);
         send_item(script_rq[i], script_n[i], script_tile[i]);
      end
      wait_quiet();

      // random part, one register setting per phase
      for (ph = 0; ph < PHASES; ph++) begin
         idle_pct = (ph < 3) ? 26 : ((ph < 6) ? 62 : 0);
         case (ph)
            0: apply_setting(16, 16, 64, 64, 8);
            1: apply_setting(0, 0, 0, 0, 0);           // all saturate up to one
            2: apply_setting(511, 511, 127, 127, 127); // all saturate down to the top
            3: apply_setting(256, 256, 64, 64, 64);
            4: apply_setting(1, 256, 64, 1, 64);
            5: apply_setting(7, 3, 9, 13, 5);
            6: apply_setting($urandom_range(256, 1), $urandom_range(256, 1),
                             $urandom_range(64, 1), $urandom_range(64, 1),
                             $urandom_range(64, 1));
            // high data bits beyond the count registers are dropped
            default: apply_setting(24, 40, 9'h18A, 9'h1FF, 9'h105);
         endcase
         for (i = 0; i < ITEMS_PER_PH; i++) begin
            // sender holds off once per phase until the block has caught up
            if (i == ITEMS_PER_PH / 2) wait_quiet();
            if ($urandom_range(99) < 25) begin
               rq = noise_item();
               rq.req_type = REQ_LOAD;
               send_item(rq, -1, '0);
            end else begin
               rq = random_view();
               preload_view(rq);
               send_item(rq, -1, '0);
            end
         end
         wait_quiet();
      end

      if (mismatches == 0 && tiles_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// File: tile_map_view_renderer.f
design/tmvr_pkg.sv
design/tmvr_ram.sv
design/tmvr_div.sv
design/tmvr_datapath.sv
design/tmvr_ctrl.sv
design/tile_map_view_renderer.sv
tb/tb_top.sv
